/* rtl/format_spec_validator_assert.svh */
// Assertion macros shared by the format string checker.
`ifndef FORMAT_SPEC_VALIDATOR_ASSERT_SVH
`define FORMAT_SPEC_VALIDATOR_ASSERT_SVH

// Same-cycle implication, held off while reset is applied.
`define FSV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while reset is applied.
`define FSV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/fsv_pkg.sv */
// Package with the parser state codes, character constants and shared types.
`timescale 1ns / 1ps
package fsv_pkg;

  localparam logic [3:0] ST_START        = 4'd0;
  localparam logic [3:0] ST_PERCENT      = 4'd1;
  localparam logic [3:0] ST_FLAG         = 4'd2;
  localparam logic [3:0] ST_WIDTH        = 4'd3;
  localparam logic [3:0] ST_WIDTH_DIGITS = 4'd4;
  localparam logic [3:0] ST_DOT          = 4'd5;
  localparam logic [3:0] ST_PRECISION    = 4'd6;
  localparam logic [3:0] ST_LONG         = 4'd7;
  localparam logic [3:0] ST_LONG_LONG    = 4'd8;
  localparam logic [3:0] ST_TYPE         = 4'd9;

  localparam logic [6:0] F_MINUS = 7'h01;
  localparam logic [6:0] F_PLUS  = 7'h02;
  localparam logic [6:0] F_SPACE = 7'h04;
  localparam logic [6:0] F_ZERO  = 7'h08;
  localparam logic [6:0] F_HASH  = 7'h10;
  localparam logic [6:0] F_COMMA = 7'h20;
  localparam logic [6:0] F_BANG  = 7'h40;

  localparam logic [1:0] W_NONE   = 2'd0;
  localparam logic [1:0] W_DIGITS = 2'd1;
  localparam logic [1:0] W_STAR   = 2'd2;

  localparam logic [1:0] L_DEFAULT   = 2'd0;
  localparam logic [1:0] L_LONG_LONG = 2'd2;

  localparam logic [1:0] FIN_PENDING = 2'd0;
  localparam logic [1:0] FIN_OK      = 2'd1;
  localparam logic [1:0] FIN_ERROR   = 2'd2;

  localparam logic [2:0] K_INT  = 3'd0;
  localparam logic [2:0] K_LONG = 3'd1;
  localparam logic [2:0] K_REAL = 3'd2;
  localparam logic [2:0] K_TEXT = 3'd3;
  localparam logic [2:0] K_DONE = 3'd4;
  localparam logic [2:0] K_ERR  = 3'd5;

  localparam logic [3:0] E_NONE        = 4'd0;
  localparam logic [3:0] E_DUP_FLAG    = 4'd1;
  localparam logic [3:0] E_PLUS_SPACE  = 4'd2;
  localparam logic [3:0] E_WIDTH       = 4'd3;
  localparam logic [3:0] E_LONE_L      = 4'd4;
  localparam logic [3:0] E_LL_BANG     = 4'd5;
  localparam logic [3:0] E_BANNED      = 4'd6;
  localparam logic [3:0] E_UNKNOWN     = 4'd7;
  localparam logic [3:0] E_BAD_FLAGS   = 4'd8;
  localparam logic [3:0] E_BAD_LENGTH  = 4'd9;
  localparam logic [3:0] E_INCOMPLETE  = 4'd10;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_L       = 8'h6C;
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_9       = 8'h39;

  typedef struct packed {
    logic [3:0] pst;
    logic [6:0] flags;
    logic [1:0] wk;
    logic [1:0] lk;
    logic [1:0] fin;
  } fsv_state_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] kind;
    logic [3:0] code;
  } fsv_res_t;

  function automatic logic [6:0] flag_bit(input logic [7:0] c);
    logic [6:0] f;
    case (c)
      8'h2D:   f = F_MINUS;
      8'h2B:   f = F_PLUS;
      8'h20:   f = F_SPACE;
      8'h30:   f = F_ZERO;
      8'h23:   f = F_HASH;
      8'h2C:   f = F_COMMA;
      8'h21:   f = F_BANG;
      default: f = 7'h00;
    endcase
    return f;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

endpackage

/* rtl/fsv_step.sv */
// Next-state and result logic for one format string byte.
`timescale 1ns / 1ps
module fsv_step import fsv_pkg::*; (
  input  fsv_state_t state_i,
  input  logic [7:0] ch_i,
  input  logic       new_string_i,
  output fsv_state_t state_o,
  output fsv_res_t   res_o
);

  fsv_state_t cur;
  fsv_state_t nxt;
  fsv_res_t   res;
  logic [6:0] fb;
  logic       go_flag;
  logic       go_width;
  logic       go_dot;
  logic       go_long;
  logic       go_type;
  logic [6:0] allowed;
  logic       length_ok;
  logic [2:0] kind;
  logic [2:0] int_kind;
  logic       banned;
  logic       unknown;

  assign fb = flag_bit(ch_i);

  always_comb begin
    cur       = new_string_i ? '0 : state_i;
    nxt       = cur;
    res       = '0;
    go_flag   = 1'b0;
    go_width  = 1'b0;
    go_dot    = 1'b0;
    go_long   = 1'b0;
    go_type   = 1'b0;
    allowed   = F_MINUS;
    length_ok = 1'b0;
    kind      = K_INT;
    banned    = 1'b0;
    unknown   = 1'b0;
    int_kind  = K_INT;

    if (cur.fin == FIN_PENDING) begin
      if (ch_i == CH_NUL) begin
        res.valid = 1'b1;
        if (cur.pst == ST_START) begin
          res.kind = K_DONE;
          nxt.fin  = FIN_OK;
        end else begin
          res.kind = K_ERR;
          res.code = E_INCOMPLETE;
          nxt.fin  = FIN_ERROR;
        end
      end else begin
        if (cur.pst == ST_START || cur.pst > ST_TYPE) begin
          nxt.pst = (ch_i == CH_PERCENT) ? ST_PERCENT : ST_START;
        end

        if (cur.pst == ST_PERCENT) begin
          if (ch_i == CH_PERCENT) begin
            nxt.pst = ST_START;
          end else begin
            go_flag = 1'b1;
          end
        end

        if (cur.pst == ST_FLAG || go_flag) begin
          if (fb != 7'h00) begin
            if ((cur.flags & fb) != 7'h00) begin
              res     = '{1'b1, K_ERR, E_DUP_FLAG};
              nxt.fin = FIN_ERROR;
            end else if (((cur.flags & (F_PLUS | F_SPACE)) != 7'h00) &&
                         ((fb & (F_PLUS | F_SPACE)) != 7'h00)) begin
              res     = '{1'b1, K_ERR, E_PLUS_SPACE};
              nxt.fin = FIN_ERROR;
            end else begin
              nxt.flags = cur.flags | fb;
              nxt.pst   = ST_FLAG;
            end
          end else begin
            go_width = 1'b1;
          end
        end

        if (cur.pst == ST_WIDTH || go_width) begin
          if (is_digit(ch_i)) begin
            nxt.wk  = W_DIGITS;
            nxt.pst = ST_WIDTH_DIGITS;
          end else if (ch_i == CH_STAR) begin
            nxt.wk  = W_STAR;
            nxt.pst = ST_DOT;
            res     = '{1'b1, K_INT, E_NONE};
          end else if ((cur.flags & (F_MINUS | F_ZERO)) != 7'h00) begin
            res     = '{1'b1, K_ERR, E_WIDTH};
            nxt.fin = FIN_ERROR;
          end else begin
            nxt.wk = W_NONE;
            go_dot = 1'b1;
          end
        end

        if (cur.pst == ST_WIDTH_DIGITS) begin
          if (!is_digit(ch_i)) begin
            go_dot = 1'b1;
          end
        end

        if (cur.pst == ST_DOT || go_dot) begin
          if (ch_i == CH_DOT) begin
            nxt.pst = ST_PRECISION;
          end else begin
            go_long = 1'b1;
          end
        end

        if (cur.pst == ST_PRECISION) begin
          if (!is_digit(ch_i)) begin
            go_long = 1'b1;
          end
        end

        if (cur.pst == ST_LONG || go_long) begin
          if (ch_i == CH_L) begin
            nxt.pst = ST_LONG_LONG;
          end else begin
            nxt.lk  = L_DEFAULT;
            go_type = 1'b1;
          end
        end

        if (cur.pst == ST_LONG_LONG) begin
          if (ch_i != CH_L) begin
            res     = '{1'b1, K_ERR, E_LONE_L};
            nxt.fin = FIN_ERROR;
          end else if ((cur.flags & F_BANG) != 7'h00) begin
            res     = '{1'b1, K_ERR, E_LL_BANG};
            nxt.fin = FIN_ERROR;
          end else begin
            nxt.lk  = L_LONG_LONG;
            nxt.pst = ST_TYPE;
          end
        end

        if (cur.pst == ST_TYPE || go_type) begin
          int_kind = (nxt.lk == L_LONG_LONG) ? K_LONG : K_INT;
          case (ch_i) inside
            8'h64, 8'h69: begin
              length_ok = 1'b1;
              allowed   = F_MINUS | F_PLUS | F_SPACE | F_ZERO | F_COMMA;
              kind      = int_kind;
            end
            8'h75: begin
              length_ok = 1'b1;
              allowed   = F_MINUS | F_ZERO;
              kind      = int_kind;
            end
            8'h66, 8'h65, 8'h45, 8'h67, 8'h47: begin
              allowed = F_MINUS | F_ZERO | F_BANG | F_HASH;
              kind    = K_REAL;
            end
            8'h78, 8'h58, 8'h6F: begin
              length_ok = 1'b1;
              allowed   = F_MINUS | F_ZERO | F_HASH;
              kind      = int_kind;
            end
            8'h73: begin
              allowed = F_MINUS | F_BANG;
              kind    = K_TEXT;
            end
            8'h63, 8'h7A, 8'h70, 8'h6E, 8'h71, 8'h51, 8'h77: begin
              banned = 1'b1;
            end
            default: begin
              unknown = 1'b1;
            end
          endcase
          if (banned) begin
            res     = '{1'b1, K_ERR, E_BANNED};
            nxt.fin = FIN_ERROR;
          end else if (unknown) begin
            res     = '{1'b1, K_ERR, E_UNKNOWN};
            nxt.fin = FIN_ERROR;
          end else if ((cur.flags | allowed) != allowed) begin
            res     = '{1'b1, K_ERR, E_BAD_FLAGS};
            nxt.fin = FIN_ERROR;
          end else if (nxt.lk != L_DEFAULT && !length_ok) begin
            res     = '{1'b1, K_ERR, E_BAD_LENGTH};
            nxt.fin = FIN_ERROR;
          end else begin
            res       = '{1'b1, kind, E_NONE};
            nxt.pst   = ST_START;
            nxt.flags = 7'h00;
            nxt.wk    = W_NONE;
            nxt.lk    = L_DEFAULT;
          end
        end
      end
    end
    state_o = nxt;
    res_o   = res;
  end

endmodule

/* rtl/format_spec_validator.sv */
// A result beat is registered and appears on the output in the cycle after its input beat is taken.
// Throughput: one format byte per cycle while in_tready is high; the parser next state is registered in state_r.
// The input stays ready while the output register is empty or being drained.
// Reset (synchronous, rst_n low) returns the parser to the start state, pending,
// with no flags, width or length, and empties the output register.
`timescale 1ns / 1ps
module format_spec_validator import fsv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,  // [7:0] format_char
  input  logic       in_tuser,  // [0] new_string
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata, // [3:0] error_code, [7:4] zero
  output logic [2:0] out_tuser  // [2:0] arg_kind
);

`include "format_spec_validator_assert.svh"

  fsv_state_t state_r;
  fsv_state_t state_nxt;
  fsv_res_t   res;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic [2:0] kind_r;
  logic [3:0] code_r;
  logic       in_fire;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  fsv_step u_step (
    .state_i      (state_r),
    .ch_i         (in_tdata),
    .new_string_i (in_tuser),
    .state_o      (state_nxt),
    .res_o        (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (in_fire) begin
      out_valid_nxt = res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res.valid) begin
      kind_r <= res.kind;
      code_r <= res.code;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, code_r};
  assign out_tuser  = kind_r;

  `FSV_ASSERT_IMP(a_code_only_on_error, out_tvalid && (out_tuser != K_ERR),
    out_tdata[3:0] == E_NONE, "error code set on a non-error result")
  `FSV_ASSERT_IMP(a_final_sets_finished,
    out_tvalid && (out_tuser == K_DONE || out_tuser == K_ERR),
    state_r.fin != FIN_PENDING, "final result without finished state")
  `FSV_ASSERT_NXT(a_silent_after_finish,
    in_fire && !in_tuser && (state_r.fin != FIN_PENDING),
    !out_tvalid && $stable(state_r), "beat after finish produced output")

endmodule
